>>> design/window_weighted_square_count_macros.svh
// Assertion macros for the windowed weighted-square counter.
// Used by the top level; needs no other file.
`ifndef WINDOW_WEIGHTED_SQUARE_COUNT_MACROS_SVH
`define WINDOW_WEIGHTED_SQUARE_COUNT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define WWS_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define WWS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/wws_pkg.sv
// Shared constants, types and codes for the windowed weighted-square counter.
// No dependencies; used by wws_mac, the top level and the bench.
`timescale 1ns / 1ps

package wws_pkg;

   // Sizing
   localparam int ELEMENT_COUNT = 4096;
   localparam int VALUE_BITS    = 16;

   // Fixed field widths
   localparam int POS_BITS   = 12;
   localparam int DATA_BITS  = 16;
   localparam int POWER_BITS = 40;

   // Derived widths
   localparam int IDX_BITS    = $clog2(ELEMENT_COUNT);
   localparam int CNT_BITS    = $clog2(ELEMENT_COUNT + 1);
   localparam int FACTOR_BITS = CNT_BITS + 1;
   localparam int PROD_BITS   = FACTOR_BITS + VALUE_BITS;
   localparam int VALUE_SPAN  = 2 ** VALUE_BITS;

   typedef logic [POS_BITS-1:0]    pos_type;
   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [VALUE_BITS-1:0]  val_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;
   typedef logic [FACTOR_BITS-1:0] factor_type;
   typedef logic [PROD_BITS-1:0]   prod_type;
   typedef logic [POWER_BITS-1:0]  power_type;

   // Command and status codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // Request to the shared multiply-accumulate unit
   typedef struct packed {
      logic       start;
      logic       sub;
      factor_type factor;
      val_type    value;
   } mac_req_type;

endpackage

>>> design/wws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/wws_mac.sv
// Shared multiply-accumulate unit: product of (2c +/- 1) and a value, then
// added to or taken from the running power. Depends on wws_pkg.
`timescale 1ns / 1ps

module wws_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  wws_pkg::mac_req_type mac_req,
   output wws_pkg::power_type   power,
   output logic                 busy
);

   wws_pkg::prod_type  prod_ff, prod_in;
   logic               sub_ff;
   logic               pend_ff;
   wws_pkg::power_type power_ff, power_in;

   // Stage one: multiply
   assign prod_in = wws_pkg::prod_type'(mac_req.factor) * wws_pkg::prod_type'(mac_req.value);

   // Stage two: accumulate, wrapping at the power width
   always_comb begin
      power_in = power_ff;
      if (pend_ff) begin
         if (sub_ff) begin
            power_in = power_ff - wws_pkg::power_type'(prod_ff);
         end else begin
            power_in = power_ff + wws_pkg::power_type'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         power_ff <= '0;
      end else begin
         pend_ff  <= mac_req.start;
         power_ff <= power_in;
      end
      if (mac_req.start) begin
         prod_ff <= prod_in;
         sub_ff  <= mac_req.sub;
      end
   end

   assign power = power_ff;
   assign busy  = pend_ff;

endmodule

>>> design/window_weighted_square_count.sv
// Windowed weighted-square counter: loads and range queries over an element array.
// Usage:
//   req_ channel carries one command per transfer. A load (command 0) writes
//   value to position and returns nothing. A query (command 1) moves the
//   window to [query_left, query_right] and returns one rsp_ transfer with
//   power = sum of count^2 * value over the window (mod 2^40) and status 0;
//   a bad range (left > right or right past the array) returns status 1,
//   power 0, and leaves the window alone.
//   A load outside the window is written at once; a load inside it takes the
//   old value out of the counts, writes, then puts the new one in. A query
//   moves the window one end step at a time, each step being plan, element
//   read, count read, then multiply and count write through the one shared
//   multiply-accumulate unit; the first query grows the window element by element.
//   req_ready is low while an item is in work.
//   After reset all 2^16 entries of the count memory are cleared one per cycle,
//   with req_ready low. The element array is not cleared.
//   A finished result sits in an output register; the block takes the next
//   item while it waits, and a later query holds in its last step until the
//   receiver has taken the earlier result.
// Depends on wws_pkg, wws_ram, wws_mac and window_weighted_square_count_macros.svh.
`timescale 1ns / 1ps
`include "window_weighted_square_count_macros.svh"

module window_weighted_square_count (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [11:0]           req_position,
   input  logic [15:0]           req_value,
   input  logic [11:0]           req_query_left,
   input  logic [11:0]           req_query_right,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [39:0]           rsp_power,
   output logic                  rsp_status
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PLAN,
      S_ERD,
      S_CRD,
      S_MUL,
      S_LWR,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   wws_pkg::val_type    clr_addr_ff, clr_addr_in;
   wws_pkg::pos_type    win_left_ff, win_left_in;
   wws_pkg::pos_type    win_right_ff, win_right_in;
   logic                win_valid_ff, win_valid_in;
   wws_pkg::pos_type    tgt_left_ff, tgt_left_in;
   wws_pkg::pos_type    tgt_right_ff, tgt_right_in;
   wws_pkg::pos_type    idx_ff, idx_in;
   logic                take_in_ff, take_in_in;
   logic                is_load_ff, is_load_in;
   logic                bad_ff, bad_in;
   wws_pkg::val_type    new_value_ff, new_value_in;
   wws_pkg::val_type    val_ff, val_in;
   logic                rsp_valid_ff, rsp_valid_in;
   wws_pkg::power_type  rsp_power_ff, rsp_power_in;
   logic                rsp_status_ff, rsp_status_in;

   logic                req_fire;
   logic                query_bad;
   logic                load_oob;
   logic                load_inside;

   logic                elem_we, elem_re;
   wws_pkg::idx_type    elem_waddr, elem_raddr;
   wws_pkg::val_type    elem_wdata, elem_rdata;
   logic                cnt_we, cnt_re;
   wws_pkg::val_type    cnt_waddr, cnt_raddr;
   wws_pkg::cnt_type    cnt_wdata, cnt_rdata;

   wws_pkg::mac_req_type mac_req;
   wws_pkg::power_type   mac_power;
   logic                 mac_busy;

   // Element array, undefined until written
   wws_ram #(
      .WIDTH (wws_pkg::VALUE_BITS),
      .DEPTH (wws_pkg::ELEMENT_COUNT)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_en   (elem_re),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata)
   );

   // Per-value occurrence counts, cleared after reset
   wws_ram #(
      .WIDTH (wws_pkg::CNT_BITS),
      .DEPTH (wws_pkg::VALUE_SPAN)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   wws_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_req (mac_req),
      .power   (mac_power),
      .busy    (mac_busy)
   );

   // Handshake and range checks
   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign query_bad   = (req_query_left > req_query_right) ||
                        (32'(req_query_right) >= 32'(wws_pkg::ELEMENT_COUNT));
   assign load_oob    = 32'(req_position) >= 32'(wws_pkg::ELEMENT_COUNT);
   assign load_inside = win_valid_ff && (req_position >= win_left_ff) &&
                        (req_position <= win_right_ff);

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      win_left_in   = win_left_ff;
      win_right_in  = win_right_ff;
      win_valid_in  = win_valid_ff;
      tgt_left_in   = tgt_left_ff;
      tgt_right_in  = tgt_right_ff;
      idx_in        = idx_ff;
      take_in_in    = take_in_ff;
      is_load_in    = is_load_ff;
      bad_in        = bad_ff;
      new_value_in  = new_value_ff;
      val_in        = val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_power_in  = rsp_power_ff;
      rsp_status_in = rsp_status_ff;

      elem_we    = 1'b0;
      elem_waddr = wws_pkg::idx_type'(idx_ff);
      elem_wdata = new_value_ff;
      elem_re    = 1'b0;
      elem_raddr = wws_pkg::idx_type'(idx_ff);
      cnt_we     = 1'b0;
      cnt_waddr  = val_ff;
      cnt_wdata  = '0;
      cnt_re     = 1'b0;
      cnt_raddr  = elem_rdata;
      mac_req    = '0;

      // Output register drains independently
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            cnt_we      = 1'b1;
            cnt_waddr   = clr_addr_ff;
            cnt_wdata   = '0;
            clr_addr_in = clr_addr_ff + wws_pkg::val_type'(1);
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               if (req_command == wws_pkg::CMD_LOAD) begin
                  if (!load_oob) begin
                     if (load_inside) begin
                        // Take the old value out, write, then put the new one in
                        idx_in       = req_position;
                        take_in_in   = 1'b0;
                        is_load_in   = 1'b1;
                        new_value_in = wws_pkg::val_type'(req_value);
                        state_in     = S_ERD;
                     end else begin
                        elem_we    = 1'b1;
                        elem_waddr = wws_pkg::idx_type'(req_position);
                        elem_wdata = wws_pkg::val_type'(req_value);
                     end
                  end
               end else begin
                  is_load_in   = 1'b0;
                  tgt_left_in  = req_query_left;
                  tgt_right_in = req_query_right;
                  if (query_bad) begin
                     bad_in   = 1'b1;
                     state_in = S_RESP;
                  end else begin
                     bad_in = 1'b0;
                     if (!win_valid_ff) begin
                        // Seed a one-element window, then grow to the right
                        win_left_in  = req_query_left;
                        win_right_in = req_query_left;
                        win_valid_in = 1'b1;
                        idx_in       = req_query_left;
                        take_in_in   = 1'b1;
                        state_in     = S_ERD;
                     end else begin
                        state_in = S_PLAN;
                     end
                  end
               end
            end
         end

         // Pick the next window end step: grow left, grow right,
         // shrink left, shrink right
         S_PLAN: begin
            if (win_left_ff > tgt_left_ff) begin
               win_left_in = win_left_ff - wws_pkg::pos_type'(1);
               idx_in      = win_left_ff - wws_pkg::pos_type'(1);
               take_in_in  = 1'b1;
               state_in    = S_ERD;
            end else if (win_right_ff < tgt_right_ff) begin
               win_right_in = win_right_ff + wws_pkg::pos_type'(1);
               idx_in       = win_right_ff + wws_pkg::pos_type'(1);
               take_in_in   = 1'b1;
               state_in     = S_ERD;
            end else if (win_left_ff < tgt_left_ff) begin
               win_left_in = win_left_ff + wws_pkg::pos_type'(1);
               idx_in      = win_left_ff;
               take_in_in  = 1'b0;
               state_in    = S_ERD;
            end else if (win_right_ff > tgt_right_ff) begin
               win_right_in = win_right_ff - wws_pkg::pos_type'(1);
               idx_in       = win_right_ff;
               take_in_in   = 1'b0;
               state_in     = S_ERD;
            end else begin
               state_in = S_RESP;
            end
         end

         S_ERD: begin
            elem_re  = 1'b1;
            state_in = S_CRD;
         end

         S_CRD: begin
            cnt_re   = 1'b1;
            val_in   = elem_rdata;
            state_in = S_MUL;
         end

         // Count update and power term; removal of a zero count is a no-op
         S_MUL: begin
            if (take_in_ff || (cnt_rdata != '0)) begin
               cnt_we        = 1'b1;
               mac_req.start = 1'b1;
               mac_req.sub   = !take_in_ff;
               mac_req.value = val_ff;
               if (take_in_ff) begin
                  cnt_wdata      = cnt_rdata + wws_pkg::cnt_type'(1);
                  mac_req.factor = {cnt_rdata, 1'b1};
               end else begin
                  cnt_wdata      = cnt_rdata - wws_pkg::cnt_type'(1);
                  mac_req.factor = {cnt_rdata - wws_pkg::cnt_type'(1), 1'b1};
               end
            end
            if (is_load_ff) begin
               state_in = take_in_ff ? S_IDLE : S_LWR;
            end else begin
               state_in = S_PLAN;
            end
         end

         S_LWR: begin
            elem_we    = 1'b1;
            take_in_in = 1'b1;
            state_in   = S_ERD;
         end

         S_RESP: begin
            if (!mac_busy && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in  = 1'b1;
               rsp_power_in  = bad_ff ? '0 : mac_power;
               rsp_status_in = bad_ff ? wws_pkg::STATUS_BAD : wws_pkg::STATUS_OK;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         win_left_ff  <= '0;
         win_right_ff <= '0;
         win_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         win_left_ff  <= win_left_in;
         win_right_ff <= win_right_in;
         win_valid_ff <= win_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tgt_left_ff   <= tgt_left_in;
      tgt_right_ff  <= tgt_right_in;
      idx_ff        <= idx_in;
      take_in_ff    <= take_in_in;
      is_load_ff    <= is_load_in;
      bad_ff        <= bad_in;
      new_value_ff  <= new_value_in;
      val_ff        <= val_in;
      rsp_power_ff  <= rsp_power_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_power  = rsp_power_ff;
   assign rsp_status = rsp_status_ff;

   // Checks
   `WWS_ASSERT_IMPLY(a_win_order, clock, reset, win_valid_ff && (state_ff == S_IDLE), win_left_ff <= win_right_ff, "window ends out of order")
   `WWS_ASSERT_IMPLY(a_rsp_source, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff == S_RESP), "result raised outside the response step")
   `WWS_ASSERT_NEXT(a_mac_pending, clock, reset, mac_req.start, mac_busy && (state_ff != S_RESP || !rsp_valid_in || rsp_valid_ff), "accumulate step missing after multiply")
   `WWS_ASSERT_IMPLY(a_cnt_idle, clock, reset, state_ff == S_IDLE, !cnt_we && !mac_req.start, "count memory or unit active while idle")

endmodule

>>> verif/tb_window_weighted_square_count.sv
// Self-checking bench for window_weighted_square_count: loads and range queries
// go in over req_, answers are checked against a window/tally model kept here.
// Depends on wws_pkg and the window_weighted_square_count top level.
`timescale 1ns / 1ps

module tb_window_weighted_square_count;

   localparam int     CLK_PERIOD     = 8;
   localparam int     RESET_CYCLES   = 11;
   localparam int     WORK_SPAN      = 256;
   localparam int     FILL_ITEMS     = WORK_SPAN;
   localparam int     RANDOM_ITEMS   = 1430;
   localparam int     DRAIN_LIMIT    = 200_000;
   localparam int     SETTLE_CYCLES  = 64;
   localparam longint TIMEOUT_CYCLES = 16_000_000;

   typedef struct packed {
      logic                          command;
      wws_pkg::pos_type              position;
      logic [wws_pkg::DATA_BITS-1:0] value;
      wws_pkg::pos_type              left_end;
      wws_pkg::pos_type              right_end;
   } bus_command_type;

   typedef struct packed {
      wws_pkg::power_type power;
      logic               status;
   } rsp_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_command = wws_pkg::CMD_LOAD;
   logic [11:0]          req_position = '0;
   logic [15:0]          req_value = '0;
   logic [11:0]          req_query_left = '0;
   logic [11:0]          req_query_right = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [39:0]          rsp_power;
   logic                 rsp_status;

   // Commands waiting to go out, and answers owed by the block
   bus_command_type command_queue[$];
   rsp_answer_type  expected_answers[$];
   bus_command_type on_bus;
   int              accepted_items = 0;
   int              phase_one_end = 0;
   int              phase_two_end = 0;
   int              mismatch_count = 0;

   // Model state: element copy, per-value tally, window and its power
   bit [wws_pkg::VALUE_BITS-1:0] element_copy [wws_pkg::ELEMENT_COUNT];
   int unsigned                  value_tally [wws_pkg::VALUE_SPAN];
   wws_pkg::power_type           window_power = '0;
   int                           win_first = 0;
   int                           win_last = 0;
   bit                           win_live = 1'b0;

   window_weighted_square_count DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_value       (req_value),
      .req_query_left  (req_query_left),
      .req_query_right (req_query_right),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_power       (rsp_power),
      .rsp_status      (rsp_status)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Element enters the window: count c -> c+1 adds (2c+1)*v
   function automatic void tally_add(input int idx);
      bit [wws_pkg::VALUE_BITS-1:0] v = element_copy[idx];
      longint unsigned              c = value_tally[v];
      window_power = window_power + wws_pkg::power_type'((2 * c + 1) * v);
      value_tally[v] = value_tally[v] + 1;
   endfunction

   // Element leaves the window: count c -> c-1 removes (2c-1)*v
   function automatic void tally_drop(input int idx);
      bit [wws_pkg::VALUE_BITS-1:0] v = element_copy[idx];
      longint unsigned              c = value_tally[v];
      if (c == 0) return;
      window_power = window_power - wws_pkg::power_type'((2 * c - 1) * v);
      value_tally[v] = value_tally[v] - 1;
   endfunction

   // Update the model for one accepted command and queue the answer it owes
   function automatic void apply_to_window(input bus_command_type cmd);
      int l;
      int r;
      bit in_window;
      l = int'(cmd.left_end);
      r = int'(cmd.right_end);
      if (cmd.command == wws_pkg::CMD_LOAD) begin
         if (int'(cmd.position) >= wws_pkg::ELEMENT_COUNT) return;
         in_window = win_live && int'(cmd.position) >= win_first &&
                     int'(cmd.position) <= win_last;
         if (in_window) tally_drop(int'(cmd.position));
         element_copy[cmd.position] = cmd.value[wws_pkg::VALUE_BITS-1:0];
         if (in_window) tally_add(int'(cmd.position));
      end else if (l > r || r >= wws_pkg::ELEMENT_COUNT) begin
         expected_answers.push_back('{power: '0, status: wws_pkg::STATUS_BAD});
      end else begin
         if (!win_live) begin
            for (int i = l; i <= r; i++) tally_add(i);
            win_first = l;
            win_last  = r;
            win_live  = 1'b1;
         end else begin
            // grow before shrinking so the window never empties
            while (win_first > l) begin
               win_first--;
               tally_add(win_first);
            end
            while (win_last < r) begin
               win_last++;
               tally_add(win_last);
            end
            while (win_first < l) begin
               tally_drop(win_first);
               win_first++;
            end
            while (win_last > r) begin
               tally_drop(win_last);
               win_last--;
            end
         end
         expected_answers.push_back('{power: window_power, status: wws_pkg::STATUS_OK});
      end
   endfunction

   // Unused fields of each command carry random noise
   function automatic bus_command_type load_cmd(input int pos, input int val);
      bus_command_type c;
      c.command   = wws_pkg::CMD_LOAD;
      c.position  = wws_pkg::pos_type'(pos);
      c.value     = val[wws_pkg::DATA_BITS-1:0];
      c.left_end  = wws_pkg::pos_type'($urandom);
      c.right_end = wws_pkg::pos_type'($urandom);
      return c;
   endfunction

   function automatic bus_command_type query_cmd(input int l, input int r);
      bus_command_type c;
      c.command   = wws_pkg::CMD_QUERY;
      c.position  = wws_pkg::pos_type'($urandom);
      c.value     = wws_pkg::DATA_BITS'($urandom);
      c.left_end  = wws_pkg::pos_type'(l);
      c.right_end = wws_pkg::pos_type'(r);
      return c;
   endfunction

   // Keep an index inside the filled part of the array
   function automatic int clip_index(input int i);
      if (i < 0) return 0;
      if (i > WORK_SPAN - 1) return WORK_SPAN - 1;
      return i;
   endfunction

   // Idle odds per phase: sender 31 / receiver 84, then swapped, then none
   function automatic bit take_a_break(input bit sender);
      int pct;
      if (accepted_items < phase_one_end) pct = sender ? 31 : 84;
      else if (accepted_items < phase_two_end) pct = sender ? 84 : 31;
      else pct = 0;
      return $urandom_range(0, 99) < pct;
   endfunction

   // Request driver: present the next command once the previous transfer is done
   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_to_window(on_bus);
            accepted_items <= accepted_items + 1;
         end
         if (!req_valid || req_ready) begin
            if (command_queue.size() > 0 && !take_a_break(1'b1)) begin
               on_bus = command_queue.pop_front();
               req_valid       <= 1'b1;
               req_command     <= on_bus.command;
               req_position    <= on_bus.position;
               req_value       <= on_bus.value;
               req_query_left  <= on_bus.left_end;
               req_query_right <= on_bus.right_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each transfer with the oldest owed answer
   always @(posedge clock) begin : check_rsp
      rsp_answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("answer with no query pending, power %0d status %0d",
                                         rsp_power, rsp_status));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_power !== want.power)
                  report_mismatch($sformatf("power %0d, expected %0d", rsp_power, want.power));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            end
         end
         rsp_ready <= !take_a_break(1'b0);
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("window_weighted_square_count regression: fail");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      int lo, hi, pos, val, l, r, query_no, drain, gen_l, gen_r;

      // Write every element a query can reach with the top value, so no query
      // reads an unwritten slot
      for (int i = 0; i < FILL_ITEMS; i++) command_queue.push_back(load_cmd(i, 16'hFFFF));

      // Directed: bad ranges, full working window at top power, loads in and
      // out of the window, big window moves, repeated and unchanged windows
      command_queue.push_back(query_cmd(5, 4));
      command_queue.push_back(query_cmd(wws_pkg::ELEMENT_COUNT - 1, 0));
      command_queue.push_back(query_cmd(0, WORK_SPAN - 1));
      command_queue.push_back(load_cmd(0, 0));
      command_queue.push_back(load_cmd(wws_pkg::ELEMENT_COUNT - 1, 1));
      command_queue.push_back(load_cmd(WORK_SPAN / 2, 16'h8000));
      command_queue.push_back(query_cmd(0, WORK_SPAN - 1));
      command_queue.push_back(query_cmd(WORK_SPAN - 1, WORK_SPAN - 1));
      command_queue.push_back(load_cmd(0, 16'hFFFF));
      command_queue.push_back(query_cmd(0, 0));
      command_queue.push_back(query_cmd(0, 1));
      command_queue.push_back(load_cmd(1, 16'h5555));
      command_queue.push_back(load_cmd(1, 16'hAAAA));
      command_queue.push_back(query_cmd(1, 1));
      command_queue.push_back(query_cmd(7, 3));
      command_queue.push_back(query_cmd(1, 1));
      command_queue.push_back(query_cmd(0, 2));
      gen_l = 0;
      gen_r = 2;

      // Random: half loads (mostly near the window), half queries (mostly small
      // moves, now and then a far jump or a very wide window, a few bad ranges)
      query_no = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 9) < 6) begin
               lo  = clip_index(gen_l - 8);
               hi  = clip_index(gen_r + 8);
               pos = int'($urandom_range(hi, lo));
            end else begin
               pos = int'($urandom_range(0, wws_pkg::ELEMENT_COUNT - 1));
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3: val = int'($urandom_range(0, 3));
               4:          val = 16'hFFFF;
               default:    val = int'($urandom_range(0, 16'hFFFF));
            endcase
            command_queue.push_back(load_cmd(pos, val));
         end else begin
            query_no++;
            if ($urandom_range(0, 99) < 6) begin
               l = int'($urandom_range(1, wws_pkg::ELEMENT_COUNT - 1));
               r = int'($urandom_range(0, l - 1));
            end else begin
               if (query_no % 97 == 0) begin
                  l = int'($urandom_range(0, 63));
                  r = int'($urandom_range(WORK_SPAN - 64, WORK_SPAN - 1));
               end else if (query_no % 40 == 0) begin
                  l = int'($urandom_range(0, WORK_SPAN - 1));
                  r = clip_index(l + int'($urandom_range(0, 32)));
               end else begin
                  l = clip_index(gen_l + int'($urandom_range(0, 32)) - 16);
                  r = clip_index(l + int'($urandom_range(0, 32)));
               end
               gen_l = l;
               gen_r = r;
            end
            command_queue.push_back(query_cmd(l, r));
         end
      end

      phase_one_end = FILL_ITEMS + (command_queue.size() - FILL_ITEMS) / 3;
      phase_two_end = FILL_ITEMS + 2 * (command_queue.size() - FILL_ITEMS) / 3;

      // Sample on the falling edge so the checks see settled values
      do @(negedge clock); while (reset || command_queue.size() > 0 || req_valid);
      drain = 0;
      while (expected_answers.size() > 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_answers.size() > 0)
         report_mismatch($sformatf("%0d answers never arrived", expected_answers.size()));

      if (mismatch_count == 0) begin
         $display("window_weighted_square_count regression: pass");
      end else begin
         $display("window_weighted_square_count regression: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/wws_pkg.sv
design/wws_ram.sv
design/wws_mac.sv
design/window_weighted_square_count.sv
verif/tb_window_weighted_square_count.sv
